>>> rtl/ordered_key_value_table_assert.svh
// Assertion macros for the ordered key/value table.
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define OKVT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("okvt assertion failed");

// Next-cycle implication, disabled during reset.
`define OKVT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("okvt assertion failed");

`else

`define OKVT_ASSERT_IMP(label, clk, rst, ante, cons)
`define OKVT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/okvt_pkg.sv
package okvt_pkg;

  localparam int ENTRIES       = 16;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ENTRIES + 1);
  localparam int OPCODE_W      = 3;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VALUE_W-1:0]      value_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_RESET   = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_END    = 2'd3
  } status_t;

  // Per-cell control, broadcast from the sequencer each cycle.
  typedef struct packed {
    logic load_key;
    logic load_value;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/okvt_if.sv
interface okvt_req_if import okvt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  key_t                item_key;
  value_t              item_value;

  modport source(output valid, opcode, item_key, item_value, input ready);
  modport sink(input valid, opcode, item_key, item_value, output ready);
endinterface

interface okvt_rsp_if import okvt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  key_t                     found_key;
  value_t                   found_value;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic                     cursor_at_end;

  modport source(output valid, status, found_key, found_value, entry_count,
                 cursor_at_end, input ready);
  modport sink(input valid, status, found_key, found_value, entry_count,
               cursor_at_end, output ready);
endinterface

>>> rtl/ordered_key_value_table.sv
// Ordered key/value table with one read cursor.
// req channel (sink): opcode, item_key, item_value; transfer on valid && ready.
//   Opcodes: insert, lookup, remove, reset cursor, advance cursor, read cursor.
// rsp channel (source): status, found_key, found_value, entry_count,
//   cursor_at_end; one response per request, in request order.
// Entries sit in a row of cells in insertion order; every cell compares its
// key against the request key in parallel and a remove shifts the cells above
// the hit down by one in the same cycle.
// Each request is captured into op_r/key_r/value_r in S_IDLE, then compared
// and applied to the cell row in S_EXEC, which also loads the response
// register; the next request is taken only once the block is back in S_IDLE.
// The response sits in an output register; a new request is taken while it
// waits, but the update of that request holds until the response register
// is free, so a stalled receiver backs up into req.ready.
// Reset (rst, synchronous) empties the table and parks the cursor at the end;
// cell contents are not cleared and are never read while unoccupied.
module ordered_key_value_table import okvt_pkg::*; (
  input logic       clk,
  input logic       rst,
  okvt_req_if.sink   req,
  okvt_rsp_if.source rsp
);

  `include "ordered_key_value_table_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [OPCODE_W-1:0] op_r;
  key_t                key_r;
  value_t              value_r;

  cnt_t count;
  cnt_t count_next;
  idx_t cursor;
  idx_t cursor_next;
  logic cursor_null;
  logic cursor_null_next;

  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  key_t                     out_key;
  value_t                   out_value;
  logic [ENTRY_COUNT_W-1:0] out_count;
  logic                     out_end;

  status_t status_c;
  key_t    okey_c;
  value_t  oval_c;

  key_t        cell_key   [ENTRIES];
  value_t      cell_value [ENTRIES];
  logic        cell_match [ENTRIES];
  cell_ctl_t   cell_ctl   [ENTRIES];
  logic [ENTRIES-1:0] hit;

  idx_t   slot;
  value_t hit_value;
  logic   found;
  logic   go;
  logic   room;
  cnt_t   cnt_dec;
  op_t    op;

  assign op = op_t'(op_r);

  // ---------------- cell row ----------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    key_t   nb_key;
    value_t nb_value;
    if (i + 1 < ENTRIES) begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_value = cell_value[i+1];
    end else begin : g_top
      assign nb_key   = cell_key[i];
      assign nb_value = cell_value[i];
    end

    okvt_cell u_cell (
      .clk            (clk),
      .ctl            (cell_ctl[i]),
      .bcast_key      (key_r),
      .bcast_value    (value_r),
      .neighbor_key   (nb_key),
      .neighbor_value (nb_value),
      .entry_key      (cell_key[i]),
      .entry_value    (cell_value[i]),
      .match          (cell_match[i])
    );

    assign hit[i] = cell_match[i] && (CNT_W'(i) < count);
  end

  // Keys are unique in the table, so at most one hit: OR-combine slot and value.
  always_comb begin
    slot      = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        slot      = slot | IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  assign found   = |hit;
  assign room    = (count < CNT_W'(ENTRIES));
  assign cnt_dec = count - CNT_W'(1);
  assign go      = (state == S_EXEC) && (!out_valid || rsp.ready);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_ctl[i] = '0;
      if (go) begin
        if (op == OP_INSERT) begin
          if (found) begin
            cell_ctl[i].load_value = hit[i];
          end else if (room && (CNT_W'(i) == count)) begin
            cell_ctl[i].load_key   = 1'b1;
            cell_ctl[i].load_value = 1'b1;
          end
        end else if (op == OP_REMOVE && found) begin
          cell_ctl[i].shift = (IDX_W'(i) >= slot);
        end
      end
    end
  end

  // ---------------- operation ----------------
  always_comb begin
    status_c         = STAT_DONE;
    okey_c           = '0;
    oval_c           = '0;
    count_next       = count;
    cursor_next      = cursor;
    cursor_null_next = cursor_null;
    unique case (op)
      OP_INSERT: begin
        if (!found) begin
          if (!room) begin
            status_c = STAT_FULL;
          end else begin
            if (count == '0) begin
              cursor_next      = '0;
              cursor_null_next = 1'b0;
            end
            count_next = count + CNT_W'(1);
          end
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          oval_c = hit_value;
        end else begin
          status_c = STAT_ABSENT;
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          status_c = STAT_ABSENT;
        end else begin
          count_next = cnt_dec;
          priority if (slot == '0) begin
            cursor_next      = '0;
            cursor_null_next = (cnt_dec == '0);
          end else if (!cursor_null) begin
            if (cursor > slot) begin
              cursor_next = cursor - IDX_W'(1);
            end else if (cursor == slot && CNT_W'(slot) >= cnt_dec) begin
              // removed the tail under the cursor: fall off the end
              cursor_next      = '0;
              cursor_null_next = 1'b1;
            end
          end else begin
            // cursor already past the end: hold it there
          end
        end
      end
      OP_RESET: begin
        cursor_next      = '0;
        cursor_null_next = (count == '0);
      end
      OP_ADVANCE: begin
        if (cursor_null) begin
          status_c = STAT_END;
        end else if (CNT_W'(cursor) + CNT_W'(1) >= count) begin
          cursor_next      = '0;
          cursor_null_next = 1'b1;
        end else begin
          cursor_next = cursor + IDX_W'(1);
        end
      end
      OP_READ: begin
        if (cursor_null || CNT_W'(cursor) >= count) begin
          status_c = STAT_END;
        end else begin
          okey_c = cell_key[cursor];
          oval_c = cell_value[cursor];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_EXEC;
      S_EXEC:  if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      cursor      <= '0;
      cursor_null <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        count       <= count_next;
        cursor      <= cursor_next;
        cursor_null <= cursor_null_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r    <= req.opcode;
      key_r   <= req.item_key;
      value_r <= req.item_value;
    end
    if (go) begin
      out_status <= status_c;
      out_key    <= okey_c;
      out_value  <= oval_c;
      out_count  <= ENTRY_COUNT_W'(count_next);
      out_end    <= cursor_null_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_key     = out_key;
  assign rsp.found_value   = out_value;
  assign rsp.entry_count   = out_count;
  assign rsp.cursor_at_end = out_end;

  // ---------------- assertions ----------------
  `OKVT_ASSERT_IMP(a_cursor_in_range, clk, rst, !cursor_null, CNT_W'(cursor) < count)
  `OKVT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(ENTRIES))
  `OKVT_ASSERT_NXT(a_accept_exec, clk, rst, req.valid && req.ready, state == S_EXEC)
  `OKVT_ASSERT_NXT(a_full_keeps_count, clk, rst, go && status_c == STAT_FULL, $stable(count))

endmodule

>>> rtl/okvt_cell.sv
module okvt_cell import okvt_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  key_t      bcast_key,
  input  value_t    bcast_value,
  input  key_t      neighbor_key,
  input  value_t    neighbor_value,
  output key_t      entry_key,
  output value_t    entry_value,
  output logic      match
);

  always_ff @(posedge clk) begin
    priority if (ctl.shift) begin
      // close the gap: take the entry from the next cell up
      entry_key   <= neighbor_key;
      entry_value <= neighbor_value;
    end else begin
      if (ctl.load_key) begin
        entry_key <= bcast_key;
      end
      if (ctl.load_value) begin
        entry_value <= bcast_value;
      end
    end
  end

  assign match = (entry_key == bcast_key);

endmodule

>>> tb/okvt_mirror_pkg.sv
package okvt_mirror_pkg;
  import okvt_pkg::*;

  // Opcodes outside the defined set; the block treats them as no-ops.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    status_t                  status;
    key_t                     found_key;
    value_t                   found_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     cursor_at_end;
  } table_reply_t;

  class okvt_mirror;
    key_t         slot_key[ENTRIES];
    value_t       slot_value[ENTRIES];
    int           occupied;
    int           cursor;
    bit           cursor_off;
    table_reply_t pending_replies[$];
    int           mismatches;

    function new();
      occupied   = 0;
      cursor     = 0;
      cursor_off = 1'b1;
      mismatches = 0;
    endfunction

    function int slot_of(key_t key);
      for (int i = 0; i < occupied; i++) begin
        if (slot_key[i] === key) return i;
      end
      return occupied;
    endfunction

    // Apply one accepted request to the mirror and queue the reply it must produce.
    function void note_request(logic [OPCODE_W-1:0] opcode, key_t key, value_t value);
      table_reply_t r;
      int           slot;
      r.status      = STAT_DONE;
      r.found_key   = '0;
      r.found_value = '0;
      slot = slot_of(key);
      case (opcode)
        OP_INSERT: begin
          if (slot < occupied) begin
            slot_value[slot] = value;
          end else if (occupied >= ENTRIES) begin
            r.status = STAT_FULL;
          end else begin
            slot_key[occupied]   = key;
            slot_value[occupied] = value;
            if (occupied == 0) begin
              cursor     = 0;
              cursor_off = 1'b0;
            end
            occupied++;
          end
        end
        OP_LOOKUP: begin
          if (slot < occupied) r.found_value = slot_value[slot];
          else r.status = STAT_ABSENT;
        end
        OP_REMOVE: begin
          if (slot >= occupied) begin
            r.status = STAT_ABSENT;
          end else begin
            // close the gap, keeping insertion order
            for (int i = slot; i + 1 < occupied; i++) begin
              slot_key[i]   = slot_key[i + 1];
              slot_value[i] = slot_value[i + 1];
            end
            occupied--;
            if (slot == 0) begin
              cursor     = 0;
              cursor_off = (occupied == 0);
            end else if (!cursor_off) begin
              if (cursor > slot) begin
                cursor--;
              end else if (cursor == slot && slot >= occupied) begin
                cursor     = 0;
                cursor_off = 1'b1;
              end
            end
          end
        end
        OP_RESET: begin
          cursor     = 0;
          cursor_off = (occupied == 0);
        end
        OP_ADVANCE: begin
          if (cursor_off) begin
            r.status = STAT_END;
          end else if (cursor + 1 >= occupied) begin
            cursor     = 0;
            cursor_off = 1'b1;
          end else begin
            cursor++;
          end
        end
        OP_READ: begin
          if (cursor_off || cursor >= occupied) begin
            r.status = STAT_END;
          end else begin
            r.found_key   = slot_key[cursor];
            r.found_value = slot_value[cursor];
          end
        end
        default: ;
      endcase
      r.entry_count   = occupied[ENTRY_COUNT_W-1:0];
      r.cursor_at_end = cursor_off;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, key_t found_key,
                              value_t found_value, logic [ENTRY_COUNT_W-1:0] entry_count,
                              logic cursor_at_end);
      table_reply_t e;
      if (pending_replies.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        mismatches++;
      end
      if (found_key !== e.found_key) begin
        $error("found_key: expected %0d, got %0d", e.found_key, found_key);
        mismatches++;
      end
      if (found_value !== e.found_value) begin
        $error("found_value: expected %h, got %h", e.found_value, found_value);
        mismatches++;
      end
      if (entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
        mismatches++;
      end
      if (cursor_at_end !== e.cursor_at_end) begin
        $error("cursor_at_end: expected %0b, got %0b", e.cursor_at_end, cursor_at_end);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> tb/ordered_key_value_table_tb.sv
module ordered_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;
  import okvt_mirror_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  okvt_req_if req();
  okvt_rsp_if rsp();

  ordered_key_value_table dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  okvt_mirror mirror = new();

  key_t key_pool[POOL_SIZE];
  int   items_sent = 0;
  int   sender_idle_pct = 0;
  int   receiver_idle_pct = 0;
  int   cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Score each transfer as seen at the edge; replies first, then new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        mirror.check_reply(rsp.status, rsp.found_key, rsp.found_value, rsp.entry_count,
                           rsp.cursor_at_end);
      end
      if (req.valid && req.ready) begin
        mirror.note_request(req.opcode, req.item_key, req.item_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ordered_key_value_table_tb failed");
      $finish;
    end
  end

  // Hold valid across back-to-back requests; drop it only for an idle gap.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input key_t key,
                              input value_t value);
    if ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.item_key   <= key;
    req.item_value <= value;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int target);
    int                  reps;
    logic [OPCODE_W-1:0] noise_op;
    while (items_sent < target) begin
      case ($urandom_range(10))
        0, 1, 2: begin
          reps = $urandom_range(16, 4);
          repeat (reps) send_request(OP_INSERT, pick_key(), pick_value());
        end
        3, 4: begin
          send_request(OP_RESET, $urandom, $urandom);
          reps = $urandom_range(18, 1);
          repeat (reps) begin
            send_request(OP_READ, $urandom, $urandom);
            send_request(OP_ADVANCE, $urandom, $urandom);
          end
        end
        5, 6: begin
          reps = $urandom_range(6, 1);
          repeat (reps) begin
            send_request(OP_REMOVE, pick_key(), pick_value());
            send_request(OP_READ, $urandom, $urandom);
          end
        end
        7: begin
          reps = $urandom_range(8, 1);
          repeat (reps) send_request(OP_LOOKUP, pick_key(), pick_value());
        end
        8: begin
          reps = $urandom_range(6, 1);
          repeat (reps) begin
            noise_op = OPCODE_W'($urandom_range(7));
            send_request(noise_op, $urandom, $urandom);
          end
        end
        9: begin
          // park the cursor somewhere, then remove around it
          send_request(OP_RESET, $urandom, $urandom);
          reps = $urandom_range(15);
          repeat (reps) send_request(OP_ADVANCE, $urandom, $urandom);
          send_request(OP_REMOVE, pick_key(), pick_value());
          send_request(OP_READ, $urandom, $urandom);
        end
        default: begin
          foreach (key_pool[i]) send_request(OP_REMOVE, key_pool[i], pick_value());
        end
      endcase
    end
  endtask

  initial begin
    req.valid      <= 1'b0;
    req.opcode     <= '0;
    req.item_key   <= '0;
    req.item_value <= '0;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct   = 6;
    receiver_idle_pct = 45;

    // empty table
    send_request(OP_READ, '0, '0);
    send_request(OP_ADVANCE, '0, '0);
    send_request(OP_RESET, '0, '0);
    send_request(OP_LOOKUP, 32'sd5, '0);
    send_request(OP_REMOVE, 32'sd5, '0);
    // first insert puts the cursor on it; extremes of key and value
    send_request(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
    send_request(OP_READ, '0, '0);
    send_request(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    send_request(OP_INSERT, 32'sd0, 32'h3f80_0000);
    send_request(OP_INSERT, -32'sd1, 32'h1234_5678);
    send_request(OP_INSERT, 32'sh7fff_ffff, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'sh7fff_ffff, '1);
    send_request(OP_ADVANCE, '1, '1);
    send_request(OP_ADVANCE, '1, '1);
    // removing the head resets the cursor
    send_request(OP_REMOVE, 32'sh8000_0000, '0);
    send_request(OP_INSERT, 32'sd55, 32'hdead_beef);
    repeat (3) send_request(OP_ADVANCE, '0, '0);
    // removal before the cursor keeps it on the same entry
    send_request(OP_REMOVE, 32'sd0, '0);
    send_request(OP_READ, '0, '0);
    // removal of the last entry under the cursor sends it to the end
    send_request(OP_REMOVE, 32'sd55, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_ADVANCE, '0, '0);
    // removal under the cursor with a successor moves onto it
    send_request(OP_INSERT, 32'sd9, 32'h4000_0000);
    send_request(OP_RESET, '0, '0);
    send_request(OP_ADVANCE, '0, '0);
    send_request(OP_REMOVE, -32'sd1, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_SPARE_LO, '1, '1);
    send_request(OP_SPARE_HI, '0, '0);

    run_random(620);
    sender_idle_pct   = 45;
    receiver_idle_pct = 6;
    run_random(1240);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(1850);
    req.valid <= 1'b0;

    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("ordered_key_value_table_tb passed");
    end else begin
      $display("ordered_key_value_table_tb failed");
    end
    $finish;
  end

endmodule
